/* sv/blr_pkg.sv */
package blr_pkg;

  // Display geometry
  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;

  // Coordinate and error-term widths
  localparam int X_W   = $clog2(DISPLAY_WIDTH);
  localparam int Y_W   = $clog2(DISPLAY_HEIGHT);
  localparam int ERR_W = ((X_W > Y_W) ? X_W : Y_W) + 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS  = 2 * (X_W + Y_W);
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * (X_W + Y_W);
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Step direction bits
  localparam int SIGN_X = 0;
  localparam int SIGN_Y = 1;

  // Walk position and error term, passed between the sequencer and the step unit
  typedef struct packed {
    logic [X_W-1:0]          x;
    logic [Y_W-1:0]          y;
    logic signed [ERR_W-1:0] err;
  } walk_t;

  typedef struct packed {
    logic [X_W-1:0] span_x;
    logic [Y_W-1:0] span_y;
    logic [1:0]     signs;
  } line_t;

endpackage

/* sv/bresenham_line_rasterizer_unit.sv */
// Bresenham line rasterizer.
// Input stream (s_*): one transaction is one line command with both
// endpoints. Output stream (m_*): the pixels of the line in walk order,
// up to two per transaction; m_tuser flags the second pixel as part of the line,
// m_tlast marks the transaction holding the end point.
// A single step unit advances the walk by one pixel per cycle while no
// result is held pending by a stalled receiver; a result is loaded once
// two pixels have been walked or the end point is reached. The longest
// line has 128 pixels and keeps s_tready low while it is walked.
// s_tready is high only while no line is being walked; the next command is
// taken as soon as the final result is loaded into the output register,
// even while that result still waits to be taken.
// When the receiver stalls with a result pending, the walk holds and no
// pixel is lost. Reset (rst, synchronous) drops any line in progress and
// any pending result and returns the block to idle.
module bresenham_line_rasterizer_unit
  import blr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // first_x, first_y, second_x, second_y
  output logic             m_tuser,  // second_valid
  output logic             m_tlast   // last_of_line
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t         state;
  walk_t          cur;
  walk_t          step_nxt;
  line_t          line;
  logic [X_W-1:0] target_x;
  logic [Y_W-1:0] target_y;
  logic           have_first;
  logic [X_W-1:0] first_x;
  logic [Y_W-1:0] first_y;

  // Command fields
  logic [X_W-1:0] in_sx;
  logic [Y_W-1:0] in_sy;
  logic [X_W-1:0] in_ex;
  logic [Y_W-1:0] in_ey;
  line_t          in_line;
  logic           proceed;
  logic           at_end;

  assign in_sx = s_tdata[X_W-1:0];
  assign in_sy = s_tdata[X_W+Y_W-1:X_W];
  assign in_ex = s_tdata[2*X_W+Y_W-1:X_W+Y_W];
  assign in_ey = s_tdata[2*X_W+2*Y_W-1:2*X_W+Y_W];

  // Spans and directions of a new command
  always_comb begin
    in_line.span_x        = (in_ex > in_sx) ? (in_ex - in_sx) : (in_sx - in_ex);
    in_line.span_y        = (in_ey > in_sy) ? (in_ey - in_sy) : (in_sy - in_ey);
    in_line.signs[SIGN_X] = !(in_sx < in_ex);
    in_line.signs[SIGN_Y] = !(in_sy < in_ey);
  end

  // Single step unit
  blr_step u_step (
    .cur  (cur),
    .line (line),
    .nxt  (step_nxt)
  );

  assign s_tready = (state == ST_IDLE);
  assign proceed  = !m_tvalid || m_tready;
  assign at_end   = (cur.x == target_x) && (cur.y == target_y);

  // Walk sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_first <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur.x      <= in_sx;
            cur.y      <= in_sy;
            cur.err    <= $signed(ERR_W'(in_line.span_x) - ERR_W'(in_line.span_y));
            target_x   <= in_ex;
            target_y   <= in_ey;
            line       <= in_line;
            have_first <= 1'b0;
            state      <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (proceed) begin
            if (!have_first) begin
              first_x <= cur.x;
              first_y <= cur.y;
              if (at_end) begin
                m_tvalid <= 1'b1;
                m_tdata  <= OUT_W'({Y_W'(0), X_W'(0), cur.y, cur.x});
                m_tuser  <= 1'b0;
                m_tlast  <= 1'b1;
                state    <= ST_IDLE;
              end else begin
                have_first <= 1'b1;
                cur        <= step_nxt;
              end
            end else begin
              m_tvalid   <= 1'b1;
              m_tdata    <= OUT_W'({cur.y, cur.x, first_y, first_x});
              m_tuser    <= 1'b1;
              m_tlast    <= at_end;
              have_first <= 1'b0;
              if (at_end) begin
                state <= ST_IDLE;
              end else begin
                cur <= step_nxt;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/blr_step.sv */
module blr_step
  import blr_pkg::*;
(
  input  walk_t cur,
  input  line_t line,
  output walk_t nxt
);

  logic signed [ERR_W:0] dbl;
  logic signed [ERR_W:0] sx;
  logic signed [ERR_W:0] sy;
  logic signed [ERR_W:0] err_sum;
  logic                  cx;
  logic                  cy;

  // Error-term compare and update, then coordinate steps
  always_comb begin
    dbl     = $signed({cur.err, 1'b0});
    sx      = $signed({{(ERR_W + 1 - X_W){1'b0}}, line.span_x});
    sy      = $signed({{(ERR_W + 1 - Y_W){1'b0}}, line.span_y});
    cx      = (dbl > -sy);
    cy      = (dbl < sx);
    err_sum = $signed({cur.err[ERR_W-1], cur.err})
              - (cx ? sy : '0) + (cy ? sx : '0);
    nxt.err = err_sum[ERR_W-1:0];
    nxt.x   = cur.x;
    nxt.y   = cur.y;
    if (cx) begin
      nxt.x = line.signs[SIGN_X] ? (cur.x - X_W'(1)) : (cur.x + X_W'(1));
    end
    if (cy) begin
      nxt.y = line.signs[SIGN_Y] ? (cur.y - Y_W'(1)) : (cur.y + Y_W'(1));
    end
  end

endmodule

/* tb/sv/bresenham_line_rasterizer_unit_test.sv */
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit_test;
  import blr_pkg::*;

  // One output transaction: up to two pixels of the walk
  typedef struct {
    logic [X_W-1:0] first_x;
    logic [Y_W-1:0] first_y;
    logic [X_W-1:0] second_x;
    logic [Y_W-1:0] second_y;
    logic           second_valid;
    logic           last_of_line;
  } pixel_pair_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // start_x, start_y, end_x, end_y
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // first_x, first_y, second_x, second_y
  logic             m_tuser;        // second_valid
  logic             m_tlast;        // last_of_line

  // Pixel pairs still owed by the block, oldest first
  pixel_pair_t pending_pixels[$];
  pixel_pair_t want;
  int          error_count = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;

  bresenham_line_rasterizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Walk the error-term line and queue the pixel pairs it produces.
  // Endpoints always fit the display, so no saturation is needed.
  task automatic rasterize_line(input logic [X_W-1:0] sx, input logic [Y_W-1:0] sy,
                                input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey);
    int          x, y, dx, dy, err, e2, n, guard;
    bit          x_down, y_down;
    pixel_pair_t pp;
    x = int'(sx);
    y = int'(sy);
    dx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
    dy = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
    x_down = !(sx < ex);
    y_down = !(sy < ey);
    err = dx - dy;
    n = 0;
    pp = '{default: '0};
    for (guard = 0; guard < 256; guard++) begin
      if (n % 2 == 0) begin
        pp = '{default: '0};
        pp.first_x = x[X_W-1:0];
        pp.first_y = y[Y_W-1:0];
      end else begin
        pp.second_x = x[X_W-1:0];
        pp.second_y = y[Y_W-1:0];
        pp.second_valid = 1'b1;
      end
      n++;
      if (x == int'(ex) && y == int'(ey)) begin
        pp.last_of_line = 1'b1;
        pending_pixels.push_back(pp);
        break;
      end
      if (n % 2 == 0) pending_pixels.push_back(pp);
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x = x_down ? x - 1 : x + 1;
      end
      if (e2 < dx) begin
        err += dx;
        y = y_down ? y - 1 : y + 1;
      end
    end
  endtask

  // Offer one line command, wait for the transaction, then predict its pixels
  task automatic send_line(input logic [X_W-1:0] sx, input logic [Y_W-1:0] sy,
                           input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey);
    logic [IN_W-1:0] word;
    word = '0;
    word[IN_BITS-1:0] = {ey, ex, sy, sx};
    if (src_gaps_on && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    rasterize_line(sx, sy, ex, ey);
  endtask

  // Receiver: random back-pressure when enabled
  always @(posedge clk) begin
    m_tready <= (sink_gaps_on && $urandom_range(99) < 34) ? 1'b0 : 1'b1;
  end

  function automatic void check_field(input string name, input int expv, input int got);
    if (expv != got) begin
      $error("%s: expected %0d, got %0d", name, expv, got);
      error_count++;
    end
  endfunction

  // Compare each output transaction with the oldest expected pixel pair
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: tdata %h tuser %0b tlast %0b", m_tdata, m_tuser, m_tlast);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("first_x", int'(want.first_x), int'(m_tdata[X_W-1:0]));
        check_field("first_y", int'(want.first_y), int'(m_tdata[X_W+Y_W-1:X_W]));
        check_field("second_x", int'(want.second_x),
                    int'(m_tdata[2*X_W+Y_W-1:X_W+Y_W]));
        check_field("second_y", int'(want.second_y),
                    int'(m_tdata[2*X_W+2*Y_W-1:2*X_W+Y_W]));
        check_field("second_valid", int'(want.second_valid), int'(m_tuser));
        check_field("last_of_line", int'(want.last_of_line), int'(m_tlast));
      end
    end
  end

  // Degenerate lines: one pixel, two pixels, three pixels
  task automatic test_short_lines();
    send_line(7'd0, 6'd0, 7'd0, 6'd0);
    send_line(7'd127, 6'd63, 7'd127, 6'd63);
    send_line(7'd10, 6'd10, 7'd11, 6'd10);
    send_line(7'd40, 6'd20, 7'd40, 6'd18);
    send_line(7'd90, 6'd33, 7'd88, 6'd35);
  endtask

  // Full-width, full-height and corner-to-corner lines in every direction
  task automatic test_extremes();
    send_line(7'd0, 6'd0, 7'd127, 6'd0);
    send_line(7'd127, 6'd63, 7'd0, 6'd63);
    send_line(7'd5, 6'd0, 7'd5, 6'd63);
    send_line(7'd100, 6'd63, 7'd100, 6'd0);
    send_line(7'd0, 6'd0, 7'd127, 6'd63);
    send_line(7'd127, 6'd63, 7'd0, 6'd0);
    send_line(7'd0, 6'd63, 7'd127, 6'd0);
    send_line(7'd127, 6'd0, 7'd0, 6'd63);
    send_line(7'd0, 6'd0, 7'd63, 6'd63);
    send_line(7'd127, 6'd0, 7'd64, 6'd63);
  endtask

  // One line in six of the eight octants, steep and shallow
  task automatic test_octants();
    send_line(7'd60, 6'd30, 7'd75, 6'd34);
    send_line(7'd60, 6'd30, 7'd64, 6'd50);
    send_line(7'd60, 6'd30, 7'd45, 6'd35);
    send_line(7'd60, 6'd30, 7'd57, 6'd10);
    send_line(7'd60, 6'd30, 7'd44, 6'd26);
    send_line(7'd60, 6'd30, 7'd67, 6'd2);
  endtask

  // Random endpoints; a third of the lines stay short
  task automatic test_random(input int count);
    int sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      sx = $urandom_range(127);
      sy = $urandom_range(63);
      if ($urandom_range(2) == 0) begin
        ex = sx + $urandom_range(6) - 3;
        ey = sy + $urandom_range(6) - 3;
        ex = (ex < 0) ? 0 : (ex > 127) ? 127 : ex;
        ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
      end else begin
        ex = $urandom_range(127);
        ey = $urandom_range(63);
      end
      send_line(sx[X_W-1:0], sy[Y_W-1:0], ex[X_W-1:0], ey[Y_W-1:0]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_lines();
    test_extremes();
    test_octants();
    test_random(150);
    // back-to-back stretch with no gaps on either side
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    test_random(100);
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    test_random(160);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("bresenham_line_rasterizer_unit_test: clean");
    end else begin
      $display("bresenham_line_rasterizer_unit_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("bresenham_line_rasterizer_unit_test: errors");
    $finish;
  end

endmodule

/* files.f */
sv/blr_pkg.sv
sv/blr_step.sv
sv/bresenham_line_rasterizer_unit.sv
tb/sv/bresenham_line_rasterizer_unit_test.sv
